// ===== rtl/rau_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rau_pkg;

    localparam int WIDTH_DEF = 16;
    localparam int OP_W      = 4;
    localparam int NUM_W     = 33;
    localparam int DEN_W     = 32;
    localparam int CMP_W     = 2;
    localparam int EXT_W     = 66;
    localparam int OUT_TW    = ((NUM_W + DEN_W + CMP_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_ADD = 4'd0,
        OP_SUB = 4'd1,
        OP_ADI = 4'd2,
        OP_MUL = 4'd3,
        OP_DIV = 4'd4,
        OP_INC = 4'd5,
        OP_DEC = 4'd6,
        OP_RED = 4'd7,
        OP_CMP = 4'd8
    } op_t;

    localparam logic [CMP_W-1:0] CMP_LT = 2'd0;
    localparam logic [CMP_W-1:0] CMP_EQ = 2'd1;
    localparam logic [CMP_W-1:0] CMP_GT = 2'd2;

    // multiplier operand pairs, one product register each
    localparam logic [1:0] MS_AN_BD = 2'd0;
    localparam logic [1:0] MS_BN_AD = 2'd1;
    localparam logic [1:0] MS_AD_BD = 2'd2;
    localparam logic [1:0] MS_AN_BN = 2'd3;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_GCD  = 6'b000100,
        S_DIV  = 6'b001000,
        S_FIN  = 6'b010000,
        S_WAIT = 6'b100000
    } state_t;

    typedef struct packed {
        logic       load;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       gcd_step;
        logic       div_init;
        logic       div_step;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic is_reduce;
        logic gcd_done;
        logic div_done;
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/rational_arithmetic_unit.sv =====
// Rational arithmetic unit: one request carries an op and two fractions a_num/a_den and
// b_num/b_den (b_num alone is the integer for add integer) and returns one result fraction,
// unreduced but for reduce, a compare code and a zero-denominator flag; a zero input
// denominator counts as one. Requests are worked one at a time. Every op except reduce makes
// four passes through the one shared WIDTH x WIDTH multiplier and then loads the result
// register. Reduce takes a dispatch step, then a binary gcd of the magnitudes, one step a
// cycle, in which each subtraction is followed by a halving; it then starts the restoring
// divider that divides both parts by the gcd at one bit a cycle, and leaves the divider
// to load the result register. A result that finds the output register still full
// waits there until it frees up. The next request is taken as soon as a result has moved into
// the output register, even while that result waits.
`timescale 1ns / 1ps
`default_nettype none

module rational_arithmetic_unit #(
    parameter int WIDTH = rau_pkg::WIDTH_DEF
) (
    input  wire                                         clk,
    input  wire                                         rst_n,
    input  wire                                         s_tvalid,
    output logic                                        s_tready,
    // op, a_num, a_den, b_num, b_den, zero pad
    input  wire  [((rau_pkg::OP_W + 4 * WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                                        m_tvalid,
    input  wire                                         m_tready,
    // res_num, res_den, cmp_result, zero pad
    output logic [rau_pkg::OUT_TW-1:0]                  m_tdata,
    // zero_den_error
    output logic [0:0]                                  m_tuser
);
    import rau_pkg::*;

    localparam int A0 = OP_W;
    localparam int A1 = OP_W + WIDTH;
    localparam int B0 = OP_W + 2 * WIDTH;
    localparam int B1 = OP_W + 3 * WIDTH;

    cmd_t                     cmd;
    status_t                  st;
    logic signed [NUM_W-1:0]  res_num;
    logic signed [DEN_W-1:0]  res_den;
    logic [CMP_W-1:0]         cmp_result;
    logic                     zero_den_error;

    rau_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .st       (st),
        .cmd      (cmd)
    );

    rau_dp #(
        .WIDTH (WIDTH)
    ) u_dp (
        .clk            (clk),
        .op             (s_tdata[OP_W-1:0]),
        .a_num          (s_tdata[A0 +: WIDTH]),
        .a_den          (s_tdata[A1 +: WIDTH]),
        .b_num          (s_tdata[B0 +: WIDTH]),
        .b_den          (s_tdata[B1 +: WIDTH]),
        .cmd            (cmd),
        .st             (st),
        .res_num        (res_num),
        .res_den        (res_den),
        .cmp_result     (cmp_result),
        .zero_den_error (zero_den_error)
    );

    assign m_tdata = OUT_TW'({cmp_result, res_den, res_num});
    assign m_tuser = zero_den_error;

endmodule

`default_nettype wire

// ===== rtl/rau_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rau_ctrl (
    input  wire             clk,
    input  wire             rst_n,
    input  wire             s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  wire             m_tready,
    input  rau_pkg::status_t st,
    output rau_pkg::cmd_t   cmd
);
    import rau_pkg::*;

    state_t     state_reg, state_next;
    logic [1:0] step_reg, step_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        s_tready   = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    step_next  = 2'd0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                if (st.is_reduce)
                begin
                    state_next = S_GCD;
                end
                else
                begin
                    cmd.mul_en  = 1'b1;
                    cmd.mul_sel = step_reg;
                    step_next   = step_reg + 2'd1;
                    if (step_reg == 2'd3)
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_GCD:
            begin
                if (st.gcd_done)
                begin
                    cmd.div_init = 1'b1;
                    state_next   = S_DIV;
                end
                else
                begin
                    cmd.gcd_step = 1'b1;
                end
            end
            S_DIV:
            begin
                if (st.div_done)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            S_FIN, S_WAIT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    state_next = S_WAIT;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rau_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rau_dp #(
    parameter int WIDTH = rau_pkg::WIDTH_DEF
) (
    input  wire                            clk,
    input  wire  [rau_pkg::OP_W-1:0]       op,
    input  wire  signed [WIDTH-1:0]        a_num,
    input  wire  signed [WIDTH-1:0]        a_den,
    input  wire  signed [WIDTH-1:0]        b_num,
    input  wire  signed [WIDTH-1:0]        b_den,
    input  rau_pkg::cmd_t                  cmd,
    output rau_pkg::status_t               st,
    output logic signed [rau_pkg::NUM_W-1:0] res_num,
    output logic signed [rau_pkg::DEN_W-1:0] res_den,
    output logic [rau_pkg::CMP_W-1:0]      cmp_result,
    output logic                           zero_den_error
);
    import rau_pkg::*;

    localparam int PW = 2 * WIDTH;
    localparam int KW = $clog2(WIDTH);
    localparam int CW = $clog2(WIDTH + 1);

    logic [OP_W-1:0]          op_reg;
    logic signed [WIDTH-1:0]  an_reg, ad_reg, bn_reg, bd_reg;
    logic [WIDTH-1:0]         abs_an_reg, abs_ad_reg;
    logic signed [PW-1:0]     prod_reg [4];

    logic [WIDTH-1:0]         gx_reg, gy_reg;
    logic [KW-1:0]            gk_reg;
    logic [WIDTH-1:0]         dvs_reg;
    logic [WIDTH-1:0]         qa_reg, qb_reg, ra_reg, rb_reg;
    logic [CW-1:0]            cnt_reg;

    logic signed [WIDTH-1:0]  ad_fix, bd_fix;
    logic signed [WIDTH-1:0]  mul_x, mul_y;
    logic signed [PW-1:0]     mul_p;
    logic [2*WIDTH-1:0]       div_a, div_b;
    logic [EXT_W-1:0]         p0e, p1e, p2e, p3e, ane, ade, qne, qde;
    logic [EXT_W-1:0]         num_ext, den_ext;
    logic [CMP_W-1:0]         cmp_next;
    logic                     err_next;

    function automatic logic [2*WIDTH-1:0] div_step(
        input logic [WIDTH-1:0] rem,
        input logic [WIDTH-1:0] quo,
        input logic [WIDTH-1:0] dvs
    );
        logic [WIDTH:0] t;
        t = {rem, quo[WIDTH-1]};
        if (t >= {1'b0, dvs})
        begin
            t = t - {1'b0, dvs};
            return {t[WIDTH-1:0], quo[WIDTH-2:0], 1'b1};
        end
        return {t[WIDTH-1:0], quo[WIDTH-2:0], 1'b0};
    endfunction

    assign ad_fix = (a_den == '0) ? WIDTH'(1) : a_den;
    assign bd_fix = (b_den == '0) ? WIDTH'(1) : b_den;

    always_comb
    begin
        case (cmd.mul_sel)
            MS_AN_BD: begin mul_x = an_reg; mul_y = bd_reg; end
            MS_BN_AD: begin mul_x = bn_reg; mul_y = ad_reg; end
            MS_AD_BD: begin mul_x = ad_reg; mul_y = bd_reg; end
            default:  begin mul_x = an_reg; mul_y = bn_reg; end
        endcase
    end

    assign mul_p = mul_x * mul_y;

    assign div_a = div_step(ra_reg, qa_reg, dvs_reg);
    assign div_b = div_step(rb_reg, qb_reg, dvs_reg);

    assign st.is_reduce = (op_reg == OP_RED);
    assign st.gcd_done  = (gx_reg == '0) || (gy_reg == '0);
    assign st.div_done  = (cnt_reg == CW'(WIDTH));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= op;
            an_reg     <= a_num;
            ad_reg     <= ad_fix;
            bn_reg     <= b_num;
            bd_reg     <= bd_fix;
            abs_an_reg <= a_num[WIDTH-1] ? WIDTH'(-a_num) : a_num;
            abs_ad_reg <= ad_fix[WIDTH-1] ? WIDTH'(-ad_fix) : ad_fix;
            gx_reg     <= a_num[WIDTH-1] ? WIDTH'(-a_num) : a_num;
            gy_reg     <= ad_fix[WIDTH-1] ? WIDTH'(-ad_fix) : ad_fix;
            gk_reg     <= '0;
        end
        else if (cmd.gcd_step)
        begin
            if (!gx_reg[0] && !gy_reg[0])
            begin
                gx_reg <= gx_reg >> 1;
                gy_reg <= gy_reg >> 1;
                gk_reg <= gk_reg + KW'(1);
            end
            else if (!gx_reg[0])
            begin
                gx_reg <= gx_reg >> 1;
            end
            else if (!gy_reg[0])
            begin
                gy_reg <= gy_reg >> 1;
            end
            else if (gx_reg >= gy_reg)
            begin
                gx_reg <= gx_reg - gy_reg;
            end
            else
            begin
                gy_reg <= gy_reg - gx_reg;
            end
        end

        if (cmd.mul_en)
        begin
            prod_reg[cmd.mul_sel] <= mul_p;
        end

        if (cmd.div_init)
        begin
            dvs_reg <= (gx_reg | gy_reg) << gk_reg;
            qa_reg  <= abs_an_reg;
            qb_reg  <= abs_ad_reg;
            ra_reg  <= '0;
            rb_reg  <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            {ra_reg, qa_reg} <= div_a;
            {rb_reg, qb_reg} <= div_b;
            cnt_reg          <= cnt_reg + CW'(1);
        end

        if (cmd.out_load)
        begin
            res_num        <= num_ext[NUM_W-1:0];
            res_den        <= den_ext[DEN_W-1:0];
            cmp_result     <= cmp_next;
            zero_den_error <= err_next;
        end
    end

    // sign extend the products and inputs, zero extend the quotients, to a common width; the ports keep the low bits
    assign p0e = EXT_W'(prod_reg[0]);
    assign p1e = EXT_W'(prod_reg[1]);
    assign p2e = EXT_W'(prod_reg[2]);
    assign p3e = EXT_W'(prod_reg[3]);
    assign ane = EXT_W'(an_reg);
    assign ade = EXT_W'(ad_reg);
    assign qne = EXT_W'(qa_reg);
    assign qde = EXT_W'(qb_reg);

    always_comb
    begin
        num_ext  = '0;
        den_ext  = '0;
        cmp_next = CMP_LT;
        err_next = 1'b0;
        case (op_reg)
            OP_ADD:
            begin
                num_ext = p0e + p1e;
                den_ext = p2e;
            end
            OP_SUB:
            begin
                num_ext = p0e - p1e;
                den_ext = p2e;
            end
            OP_ADI:
            begin
                num_ext = ane + p1e;
                den_ext = ade;
            end
            OP_MUL:
            begin
                num_ext = p3e;
                den_ext = p2e;
            end
            OP_DIV:
            begin
                num_ext = p0e;
                if (prod_reg[1] == '0)
                begin
                    err_next = 1'b1;
                    den_ext  = EXT_W'(1);
                end
                else
                begin
                    den_ext = p1e;
                end
            end
            OP_INC:
            begin
                num_ext = ane + ade;
                den_ext = ade;
            end
            OP_DEC:
            begin
                num_ext = ane - ade;
                den_ext = ade;
            end
            OP_RED:
            begin
                if (an_reg == ad_reg)
                begin
                    num_ext = EXT_W'(1);
                    den_ext = EXT_W'(1);
                end
                else
                begin
                    num_ext = an_reg[WIDTH-1] ? -qne : qne;
                    den_ext = ad_reg[WIDTH-1] ? -qde : qde;
                end
            end
            OP_CMP:
            begin
                if (prod_reg[0] == prod_reg[1])
                begin
                    cmp_next = CMP_EQ;
                end
                else if ((prod_reg[0] > prod_reg[1]) != (ad_reg[WIDTH-1] ^ bd_reg[WIDTH-1]))
                begin
                    cmp_next = CMP_GT;
                end
                else
                begin
                    cmp_next = CMP_LT;
                end
            end
            default:
            begin
                num_ext = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== bench/rational_arithmetic_unit_tb.sv =====
`timescale 1ns / 1ps

module rational_arithmetic_unit_tb;
    import rau_pkg::*;

    localparam int WIDTH       = 16;
    localparam int IN_TW       = ((OP_W + 4 * WIDTH + 7) / 8) * 8;
    localparam int RANDOM_REQS = 1750;
    localparam int MAX_GAP     = 18;
    localparam int DRAIN_WAIT  = 100;

    localparam logic [OP_W-1:0]  OP_UNUSED_LO = 4'd9;
    localparam logic [OP_W-1:0]  OP_UNUSED_HI = 4'd15;
    localparam logic [CMP_W-1:0] CMP_NONE     = '0;

    typedef logic signed [63:0] wide_t;

    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic signed [WIDTH-1:0] a_num;
        logic signed [WIDTH-1:0] a_den;
        logic signed [WIDTH-1:0] b_num;
        logic signed [WIDTH-1:0] b_den;
    } request_t;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic [CMP_W-1:0] cmp;
        logic             err;
    } rational_t;

    typedef struct {
        request_t  req;
        bit        known;
        rational_t want;
    } row_t;

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    // op, a_num, a_den, b_num, b_den, zero pad
    logic [IN_TW-1:0] s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    // res_num, res_den, cmp_result, zero pad
    logic [OUT_TW-1:0] m_tdata;
    // zero_den_error
    logic [0:0]       m_tuser;

    rational_t pending_results[$];
    row_t      directed_rows[$];
    int        mismatches;
    bit        src_burst;
    bit        sink_burst;

    rational_arithmetic_unit #(
        .WIDTH(WIDTH)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic rational_t rational_op(input request_t r);
        wide_t     an;
        wide_t     ad;
        wide_t     bn;
        wide_t     bd;
        wide_t     n;
        wide_t     d;
        wide_t     x;
        wide_t     y;
        wide_t     t;
        wide_t     lhs;
        wide_t     rhs;
        bit        flip;
        rational_t res;
        an  = wide_t'(r.a_num);
        ad  = wide_t'(r.a_den);
        bn  = wide_t'(r.b_num);
        bd  = wide_t'(r.b_den);
        n   = 0;
        d   = 0;
        res = '0;
        if (ad == 0)
            ad = 1;
        if (bd == 0)
            bd = 1;
        case (r.op)
            OP_ADD:
            begin
                n = an * bd + bn * ad;
                d = ad * bd;
            end
            OP_SUB:
            begin
                n = an * bd - bn * ad;
                d = ad * bd;
            end
            OP_ADI:
            begin
                n = an + bn * ad;
                d = ad;
            end
            OP_MUL:
            begin
                n = an * bn;
                d = ad * bd;
            end
            OP_DIV:
            begin
                n = an * bd;
                d = ad * bn;
                if (d == 0)
                begin
                    res.err = 1'b1;
                    d = 1;
                end
            end
            OP_INC:
            begin
                n = an + ad;
                d = ad;
            end
            OP_DEC:
            begin
                n = an - ad;
                d = ad;
            end
            OP_RED:
            begin
                if (an == ad)
                begin
                    n = 1;
                    d = 1;
                end
                else
                begin
                    x = (an < 0) ? -an : an;
                    y = (ad < 0) ? -ad : ad;
                    while (y != 0)
                    begin
                        t = x % y;
                        x = y;
                        y = t;
                    end
                    n = an / x;
                    d = ad / x;
                end
            end
            OP_CMP:
            begin
                lhs  = an * bd;
                rhs  = bn * ad;
                flip = (ad < 0) != (bd < 0);
                if (lhs == rhs)
                    res.cmp = CMP_EQ;
                else if ((lhs > rhs) != flip)
                    res.cmp = CMP_GT;
                else
                    res.cmp = CMP_LT;
            end
            default:
            begin
            end
        endcase
        res.num = n[NUM_W-1:0];
        res.den = d[DEN_W-1:0];
        return res;
    endfunction

    function automatic logic signed [WIDTH-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return {1'b1, {(WIDTH - 1){1'b0}}};
            2: return {1'b0, {(WIDTH - 1){1'b1}}};
            3: return '1;
            4, 5, 6: return WIDTH'(int'($urandom_range(0, 64)) - 32);
            default: return WIDTH'($urandom);
        endcase
    endfunction

    function automatic request_t random_request();
        request_t r;
        int       k;
        if ($urandom_range(0, 19) == 0)
            r.op = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        else
            r.op = OP_W'($urandom_range(OP_ADD, OP_CMP));
        r.a_num = pick_value();
        r.a_den = pick_value();
        r.b_num = pick_value();
        r.b_den = pick_value();
        k = $urandom_range(1, 300);
        case (r.op)
            OP_DIV:
                if ($urandom_range(0, 4) == 0)
                    r.b_num = '0;
            OP_RED:
                if ($urandom_range(0, 7) == 0)
                    r.a_den = r.a_num;
                else if ($urandom_range(0, 1) == 1)
                begin
                    r.a_num = WIDTH'(k * (int'($urandom_range(0, 200)) - 100));
                    r.a_den = WIDTH'(k * (int'($urandom_range(0, 200)) - 100));
                end
            OP_CMP:
                if ($urandom_range(0, 2) == 0)
                begin
                    k = int'($urandom_range(0, 50)) - 25;
                    r.a_num = WIDTH'(int'($urandom_range(0, 200)) - 100);
                    r.a_den = WIDTH'(int'($urandom_range(0, 200)) - 100);
                    r.b_num = WIDTH'(k * int'(r.a_num));
                    r.b_den = WIDTH'(k * int'(r.a_den));
                end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic add_check(input logic [OP_W-1:0] op, input int an, input int ad,
                             input int bn, input int bd);
        row_t row;
        row.req   = '{op, WIDTH'(an), WIDTH'(ad), WIDTH'(bn), WIDTH'(bd)};
        row.known = 1'b0;
        row.want  = '0;
        directed_rows.push_back(row);
    endtask

    task automatic add_known(input logic [OP_W-1:0] op, input int an, input int ad,
                             input int bn, input int bd, input longint num,
                             input longint den, input logic [CMP_W-1:0] cmp, input bit err);
        row_t row;
        row.req   = '{op, WIDTH'(an), WIDTH'(ad), WIDTH'(bn), WIDTH'(bd)};
        row.known = 1'b1;
        row.want  = '{NUM_W'(num), DEN_W'(den), cmp, err};
        directed_rows.push_back(row);
    endtask

    task automatic issue_request(input request_t req, input rational_t want);
        int gap;
        if ($urandom_range(0, 63) == 0)
            src_burst = !src_burst;
        gap = src_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tdata  <= IN_TW'({req.b_den, req.b_num, req.a_den, req.a_num, req.op});
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(want);
    endtask

    task automatic note_mismatch(input string what, input logic [63:0] want_v,
                                 input logic [63:0] got_v);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want_v, got_v);
    endtask

    always @(posedge clk)
    begin
        rational_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                note_mismatch("unrequested result", '0, m_tdata[63:0]);
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[NUM_W-1:0] !== want.num)
                    note_mismatch("res_num", want.num, m_tdata[NUM_W-1:0]);
                if (m_tdata[NUM_W+DEN_W-1:NUM_W] !== want.den)
                    note_mismatch("res_den", want.den, m_tdata[NUM_W+DEN_W-1:NUM_W]);
                if (m_tdata[NUM_W+DEN_W+CMP_W-1:NUM_W+DEN_W] !== want.cmp)
                    note_mismatch("cmp_result", want.cmp,
                                  m_tdata[NUM_W+DEN_W+CMP_W-1:NUM_W+DEN_W]);
                if (m_tuser[0] !== want.err)
                    note_mismatch("zero_den_error", want.err, m_tuser[0]);
            end
        end
    end

    initial
    begin
        int stall;
        m_tready   = 1'b0;
        sink_burst = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 63) == 0)
                sink_burst = !sink_burst;
            stall = sink_burst ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    initial
    begin
        request_t req;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        mismatches = 0;
        src_burst  = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        add_check(OP_ADD, 1, 2, 1, 3);
        add_known(OP_ADD, 3, 0, 4, 0, 7, 1, CMP_NONE, 1'b0);
        add_check(OP_SUB, -32768, -32768, 32767, 32767);
        add_known(OP_ADI, 0, 0, 5, 0, 5, 1, CMP_NONE, 1'b0);
        add_check(OP_ADI, 32767, -32768, -32768, 7);
        add_known(OP_MUL, -32768, -32768, -32768, -32768, 1073741824, 1073741824,
                  CMP_NONE, 1'b0);
        add_check(OP_MUL, 32767, -32768, -32768, 32767);
        add_known(OP_DIV, 3, 4, 0, 5, 15, 1, CMP_NONE, 1'b1);
        add_known(OP_DIV, -7, 0, 0, 0, -7, 1, CMP_NONE, 1'b1);
        add_check(OP_DIV, -32768, 32767, 32767, -32768);
        add_known(OP_INC, 5, 0, 0, 0, 6, 1, CMP_NONE, 1'b0);
        add_check(OP_DEC, -32768, 32767, 0, 0);
        add_known(OP_RED, 6, 6, 0, 0, 1, 1, CMP_NONE, 1'b0);
        add_known(OP_RED, 1, 0, 0, 0, 1, 1, CMP_NONE, 1'b0);
        add_known(OP_RED, 0, 0, 0, 0, 0, 1, CMP_NONE, 1'b0);
        add_known(OP_RED, 0, -5, 0, 0, 0, -1, CMP_NONE, 1'b0);
        add_known(OP_RED, -12, 18, 0, 0, -2, 3, CMP_NONE, 1'b0);
        add_known(OP_RED, -32768, -32768, 0, 0, 1, 1, CMP_NONE, 1'b0);
        add_known(OP_RED, -32768, 16384, 0, 0, -2, 1, CMP_NONE, 1'b0);
        add_check(OP_RED, 32767, -32768, 0, 0);
        add_known(OP_CMP, 1, 2, 1, 3, 0, 0, CMP_GT, 1'b0);
        add_known(OP_CMP, 1, -2, 1, 3, 0, 0, CMP_LT, 1'b0);
        add_known(OP_CMP, 2, 4, 1, 2, 0, 0, CMP_EQ, 1'b0);
        add_known(OP_CMP, -1, -2, 1, 2, 0, 0, CMP_EQ, 1'b0);
        add_known(OP_CMP, -32768, 1, 32767, 1, 0, 0, CMP_LT, 1'b0);
        add_known(OP_UNUSED_LO, 123, -45, 678, -9, 0, 0, CMP_NONE, 1'b0);
        add_known(OP_UNUSED_HI, -1, -1, -1, -1, 0, 0, CMP_NONE, 1'b0);

        foreach (directed_rows[i])
            issue_request(directed_rows[i].req,
                          directed_rows[i].known ? directed_rows[i].want
                                                 : rational_op(directed_rows[i].req));

        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            if (n % 400 == 200)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                while (pending_results.size() != 0)
                    @(posedge clk);
            end
            req = random_request();
            issue_request(req, rational_op(req));
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
